@@ src/polyline_nearest_cut_finder_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the nearest cut finder
// Short forms for clocked implication checks, with reset disabling them.
// ---------------------------------------------------------------------------
`ifndef POLYLINE_NEAREST_CUT_FINDER_ASSERT_SVH
`define POLYLINE_NEAREST_CUT_FINDER_ASSERT_SVH

// Same-cycle implication.
`define PNC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication.
`define PNC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ src/pnc_pkg.sv @@
// ---------------------------------------------------------------------------
// Nearest cut finder package
// Codes and the command and status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package pnc_pkg;

  localparam logic [7:0] REG_TARGET_X   = 8'd0;
  localparam logic [7:0] REG_TARGET_Y   = 8'd1;
  localparam logic [7:0] REG_CAPTURE    = 8'd2;
  localparam logic [7:0] REG_STUB_LEN   = 8'd3;

  localparam logic [1:0] STATUS_CUT     = 2'd0;
  localparam logic [1:0] STATUS_FEW     = 2'd1;
  localparam logic [1:0] STATUS_FAR     = 2'd2;
  localparam logic [1:0] STATUS_STUB    = 2'd3;

  // Operand pair that the shared multiplier works on.
  typedef enum logic [3:0] {
    MUL_NONE = 4'd0,
    MUL_DXX  = 4'd1,
    MUL_DYY  = 4'd2,
    MUL_PXDX = 4'd3,
    MUL_PYDY = 4'd4,
    MUL_DXT  = 4'd5,
    MUL_DYT  = 4'd6,
    MUL_EXX  = 4'd7,
    MUL_EYY  = 4'd8,
    MUL_CXX  = 4'd9,
    MUL_CYY  = 4'd10,
    MUL_RR   = 4'd11
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     adv;
    logic     div_init;
    logic     div_step;
    logic     sq_start;
    logic     sq_part;
    logic     upd_best;
    logic     run_upd;
    logic     emit;
    mul_sel_t mul_sel;
  } cmd_t;

  typedef struct packed {
    logic seg_en;
    logic vc_ok;
    logic last;
    logic div_need;
    logic better;
    logic sq_done;
  } stat_t;

endpackage

@@ src/pnc_isqrt.sv @@
// ---------------------------------------------------------------------------
// Integer square root
// Floor square root of a 68-bit value, two radicand bits per cycle.
// ---------------------------------------------------------------------------
module pnc_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [67:0] radicand,
  output logic        done,
  output logic [33:0] root
);

  localparam int STEPS = 34;

  logic        busy;
  logic [5:0]  cnt;
  logic [67:0] xs;
  logic [35:0] rem;
  logic [37:0] rem_t;
  logic [37:0] trial;
  logic [37:0] diff;
  logic        ge;

  assign rem_t = {rem, xs[67:66]};
  assign trial = {2'b00, root, 2'b01};
  assign diff  = rem_t - trial;
  assign ge    = rem_t >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xs   <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      xs   <= {xs[65:0], 2'b00};
      rem  <= ge ? diff[35:0] : rem_t[35:0];
      root <= {root[32:0], ge};
    end
  end

endmodule

@@ src/pnc_ctrl.sv @@
// ---------------------------------------------------------------------------
// Nearest cut finder controller
// Sequences one vertex through multiplier, divider and square root steps.
// ---------------------------------------------------------------------------
module pnc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  input  pnc_pkg::stat_t st,
  output pnc_pkg::cmd_t  cmd
);
  import pnc_pkg::*;

  typedef enum logic [26:0] {
    S_IDLE  = 27'b1 << 0,
    S_DISP  = 27'b1 << 1,
    S_DXX   = 27'b1 << 2,
    S_DYY   = 27'b1 << 3,
    S_PXDX  = 27'b1 << 4,
    S_PYDY  = 27'b1 << 5,
    S_WB1   = 27'b1 << 6,
    S_DIVI  = 27'b1 << 7,
    S_DIV   = 27'b1 << 8,
    S_DXT   = 27'b1 << 9,
    S_DYT   = 27'b1 << 10,
    S_EXX   = 27'b1 << 11,
    S_EYY   = 27'b1 << 12,
    S_WB2   = 27'b1 << 13,
    S_DEC   = 27'b1 << 14,
    S_CXX   = 27'b1 << 15,
    S_CYY   = 27'b1 << 16,
    S_WB3   = 27'b1 << 17,
    S_PSQ   = 27'b1 << 18,
    S_PWAIT = 27'b1 << 19,
    S_LEN   = 27'b1 << 20,
    S_LWAIT = 27'b1 << 21,
    S_ADV   = 27'b1 << 22,
    S_END   = 27'b1 << 23,
    S_RR    = 27'b1 << 24,
    S_WB4   = 27'b1 << 25,
    S_OUT   = 27'b1 << 26
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [3:0] div_cnt;
  logic       out_valid;
  logic       slot_free;

  assign s_tready  = (state == S_IDLE);
  assign m_tvalid  = out_valid;
  assign slot_free = !out_valid || m_tready;

  always_comb begin
    cmd        = '0;
    cmd.mul_sel = MUL_NONE;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (st.seg_en) begin
          state_next = S_DXX;
        end else if (st.vc_ok) begin
          state_next = S_ADV;
        end else begin
          state_next = S_END;
        end
      end
      S_DXX:  begin cmd.mul_sel = MUL_DXX;  state_next = S_DYY;  end
      S_DYY:  begin cmd.mul_sel = MUL_DYY;  state_next = S_PXDX; end
      S_PXDX: begin cmd.mul_sel = MUL_PXDX; state_next = S_PYDY; end
      S_PYDY: begin cmd.mul_sel = MUL_PYDY; state_next = S_WB1;  end
      S_WB1:  state_next = S_DIVI;
      S_DIVI: begin
        cmd.div_init = 1'b1;
        state_next   = st.div_need ? S_DIV : S_DXT;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt == 4'd15) begin
          state_next = S_DXT;
        end
      end
      S_DXT:  begin cmd.mul_sel = MUL_DXT; state_next = S_DYT; end
      S_DYT:  begin cmd.mul_sel = MUL_DYT; state_next = S_EXX; end
      S_EXX:  begin cmd.mul_sel = MUL_EXX; state_next = S_EYY; end
      S_EYY:  begin cmd.mul_sel = MUL_EYY; state_next = S_WB2; end
      S_WB2:  state_next = S_DEC;
      S_DEC:  state_next = st.better ? S_CXX : S_LEN;
      S_CXX:  begin cmd.mul_sel = MUL_CXX; state_next = S_CYY; end
      S_CYY:  begin cmd.mul_sel = MUL_CYY; state_next = S_WB3; end
      S_WB3:  state_next = S_PSQ;
      S_PSQ: begin
        cmd.sq_start = 1'b1;
        cmd.sq_part  = 1'b1;
        state_next   = S_PWAIT;
      end
      S_PWAIT: begin
        if (st.sq_done) begin
          cmd.upd_best = 1'b1;
          state_next   = S_LEN;
        end
      end
      S_LEN: begin
        cmd.sq_start = 1'b1;
        state_next   = S_LWAIT;
      end
      S_LWAIT: begin
        if (st.sq_done) begin
          cmd.run_upd = 1'b1;
          state_next  = S_ADV;
        end
      end
      S_ADV: begin
        cmd.adv    = 1'b1;
        state_next = S_END;
      end
      S_END:  state_next = st.last ? S_RR : S_IDLE;
      S_RR:   begin cmd.mul_sel = MUL_RR; state_next = S_WB4; end
      S_WB4:  state_next = S_OUT;
      S_OUT: begin
        if (slot_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DIV) begin
        div_cnt <= div_cnt + 4'd1;
      end else begin
        div_cnt <= '0;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ src/pnc_datapath.sv @@
// ---------------------------------------------------------------------------
// Nearest cut finder datapath
// Shared multiplier, Q0.16 divider, square root unit and polyline state.
// ---------------------------------------------------------------------------
module pnc_datapath #(
  parameter int MAX_POINTS = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic [7:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic signed [31:0]  in_x,
  input  logic signed [31:0]  in_y,
  input  logic                in_last,
  input  pnc_pkg::cmd_t       cmd,
  output pnc_pkg::stat_t      st,
  output logic [1:0]          out_status,
  output logic [11:0]         out_seg,
  output logic [31:0]         out_x,
  output logic [31:0]         out_y
);
  import pnc_pkg::*;

  localparam int VW = $clog2(MAX_POINTS + 1);
  localparam int IW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;

  function automatic logic [32:0] mag33(input logic [32:0] v);
    logic [33:0] w;
    w = {v[32], v};
    if (v[32]) begin
      w = -w;
    end
    return w[32:0];
  endfunction

  // Round (a * 65536 +/- p) / 65536 to integer, halves away from zero.
  function automatic logic [31:0] round_q16(input logic [31:0] a, input logic [65:0] p,
                                            input logic neg);
    logic [51:0] sv;
    logic [51:0] pv;
    logic [51:0] mv;
    logic [51:0] rv;
    pv = neg ? -p[51:0] : p[51:0];
    sv = {{4{a[31]}}, a, 16'h0000} + pv;
    mv = sv[51] ? -sv : sv;
    rv = (mv + 52'd32768) >> 16;
    if (sv[51]) begin
      rv = -rv;
    end
    return rv[31:0];
  endfunction

  // Configuration.
  logic [31:0] tx, ty;
  logic [30:0] cap, stub_len;

  // Polyline state.
  logic [31:0]   prev_x, prev_y;
  logic [VW-1:0] vc;
  logic [63:0]   best;
  logic [IW-1:0] best_index;
  logic [31:0]   best_cx, best_cy;
  logic [48:0]   lbc;
  logic [47:0]   running;

  // Per-vertex working registers.
  logic [31:0] px, py;
  logic        last;
  logic [32:0] dx, dy, ex0, ey0;
  logic [67:0] len2;
  logic [69:0] dot;
  logic [68:0] rem;
  logic [16:0] t;
  logic [31:0] cx, cy;
  logic [64:0] d2;
  logic [67:0] sq;
  logic [61:0] rr;

  // Multiplier.
  logic [32:0] op_a, op_b;
  logic [65:0] prod;
  logic        prod_neg;
  mul_sel_t    prod_sel;
  logic [69:0] sprod;

  logic [32:0] ex, ey, cxa, cya;
  logic        dot_le0, dot_ge;
  logic [69:0] rem2;
  logic [69:0] rem_diff;
  logic [63:0] d2_sat;
  logic        sq_done;
  logic [33:0] sq_root;
  logic [48:0] run49, after;
  logic        far, stub;
  logic [1:0]  status;
  logic [IW+11:0] index_ext;

  assign ex  = {cx[31], cx} - {tx[31], tx};
  assign ey  = {cy[31], cy} - {ty[31], ty};
  assign cxa = {cx[31], cx} - {prev_x[31], prev_x};
  assign cya = {cy[31], cy} - {prev_y[31], prev_y};

  always_comb begin
    case (cmd.mul_sel)
      MUL_DXX:  begin op_a = dx;  op_b = dx; end
      MUL_DYY:  begin op_a = dy;  op_b = dy; end
      MUL_PXDX: begin op_a = ex0; op_b = dx; end
      MUL_PYDY: begin op_a = ey0; op_b = dy; end
      MUL_DXT:  begin op_a = dx;  op_b = {16'h0000, t}; end
      MUL_DYT:  begin op_a = dy;  op_b = {16'h0000, t}; end
      MUL_EXX:  begin op_a = ex;  op_b = ex; end
      MUL_EYY:  begin op_a = ey;  op_b = ey; end
      MUL_CXX:  begin op_a = cxa; op_b = cxa; end
      MUL_CYY:  begin op_a = cya; op_b = cya; end
      MUL_RR:   begin op_a = {2'b00, cap}; op_b = {2'b00, cap}; end
      default:  begin op_a = '0;  op_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod     <= 66'(mag33(op_a)) * 66'(mag33(op_b));
    prod_neg <= op_a[32] ^ op_b[32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_sel <= MUL_NONE;
    end else begin
      prod_sel <= cmd.mul_sel;
    end
  end

  assign sprod = prod_neg ? -{4'h0, prod} : {4'h0, prod};

  // Product writeback, in the cycle after the multiply is issued.
  always_ff @(posedge clk) begin
    case (prod_sel)
      MUL_DXX:  len2 <= {2'b00, prod};
      MUL_DYY:  len2 <= len2 + {2'b00, prod};
      MUL_PXDX: dot  <= sprod;
      MUL_PYDY: dot  <= dot + sprod;
      MUL_DXT:  cx   <= round_q16(prev_x, prod, prod_neg);
      MUL_DYT:  cy   <= round_q16(prev_y, prod, prod_neg);
      MUL_EXX:  d2   <= {1'b0, prod[63:0]};
      MUL_EYY:  d2   <= d2 + {1'b0, prod[63:0]};
      MUL_CXX:  sq   <= {2'b00, prod};
      MUL_CYY:  sq   <= sq + {2'b00, prod};
      MUL_RR:   rr   <= prod[61:0];
      default:  ;
    endcase
  end

  // Projection parameter t, restoring division one quotient bit a cycle.
  assign dot_le0  = dot[69] || (dot == '0);
  assign dot_ge   = dot[68:0] >= {1'b0, len2};
  assign rem2     = {rem, 1'b0};
  assign rem_diff = rem2 - {2'b00, len2};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem <= dot[68:0];
      if (dot_le0) begin
        t <= '0;
      end else if (dot_ge) begin
        t <= 17'h10000;
      end else begin
        t <= '0;
      end
    end else if (cmd.div_step) begin
      if (rem2 >= {2'b00, len2}) begin
        rem <= rem_diff[68:0];
        t   <= {t[15:0], 1'b1};
      end else begin
        rem <= rem2[68:0];
        t   <= {t[15:0], 1'b0};
      end
    end
  end

  pnc_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sq_start),
    .radicand (cmd.sq_part ? sq : len2),
    .done     (sq_done),
    .root     (sq_root)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px   <= in_x;
      py   <= in_y;
      last <= in_last;
      dx   <= {in_x[31], in_x} - {prev_x[31], prev_x};
      dy   <= {in_y[31], in_y} - {prev_y[31], prev_y};
      ex0  <= {tx[31], tx} - {prev_x[31], prev_x};
      ey0  <= {ty[31], ty} - {prev_y[31], prev_y};
    end
  end

  assign d2_sat = d2[64] ? '1 : d2[63:0];

  assign st.vc_ok    = vc < VW'(MAX_POINTS);
  assign st.seg_en   = st.vc_ok && (vc != '0);
  assign st.last     = last;
  assign st.div_need = !dot_le0 && !dot_ge;
  assign st.better   = d2_sat < best;
  assign st.sq_done  = sq_done;

  // End-of-polyline status.
  assign run49  = {1'b0, running};
  assign after  = (run49 >= lbc) ? run49 - lbc : '0;
  assign far    = best > {2'b00, rr};
  assign stub   = (lbc < {18'h0, stub_len}) || (after < {18'h0, stub_len});
  assign index_ext = {12'h000, best_index};

  always_comb begin
    if (vc < VW'(2)) begin
      status = STATUS_FEW;
    end else if (far) begin
      status = STATUS_FAR;
    end else if (stub) begin
      status = STATUS_STUB;
    end else begin
      status = STATUS_CUT;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status <= status;
      if (status == STATUS_CUT) begin
        out_seg <= index_ext[11:0];
        out_x   <= best_cx;
        out_y   <= best_cy;
      end else begin
        out_seg <= '0;
        out_x   <= '0;
        out_y   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx       <= '0;
      ty       <= '0;
      cap      <= '0;
      stub_len <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TARGET_X: tx       <= cfg_data;
        REG_TARGET_Y: ty       <= cfg_data;
        REG_CAPTURE:  cap      <= cfg_data[30:0];
        REG_STUB_LEN: stub_len <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      prev_x     <= '0;
      prev_y     <= '0;
      vc         <= '0;
      best       <= '1;
      best_index <= '0;
      best_cx    <= '0;
      best_cy    <= '0;
      lbc        <= '0;
      running    <= '0;
    end else begin
      if (cmd.upd_best) begin
        best       <= d2_sat;
        best_index <= vc[IW-1:0];
        best_cx    <= cx;
        best_cy    <= cy;
        lbc        <= run49 + {15'h0, sq_root};
      end
      if (cmd.run_upd) begin
        running <= running + {14'h0, sq_root};
      end
      if (cmd.adv) begin
        prev_x <= px;
        prev_y <= py;
        vc     <= vc + VW'(1);
      end
    end
  end

endmodule

@@ src/polyline_nearest_cut_finder.sv @@
// ---------------------------------------------------------------------------
// Polyline nearest cut finder
// Finds the point of a streamed polyline closest to a target and checks it.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Beat contents
//   s_*      in         one vertex: tdata = point_x, point_y; tlast = last_point
//   m_*      out        one result per polyline: tuser = status;
//                       tdata = cut_segment, cut_x, cut_y
//   cfg_*    in         register write: cfg_index selects, cfg_data is the value
//
// A vertex that closes a segment goes through the multiplier, divider and square
// root steps before the next ready cycle; the Q0.16 division runs only when the
// projection falls inside the segment, and a segment that becomes the new nearest
// one adds two more multiplies and a second square root run. The first vertex of
// a polyline skips these steps, and a vertex past the limit skips them and is not
// kept. Each square root run holds the controller until it is done; the last
// vertex adds the result states. Reset is synchronous and clears the registers and the polyline state.
// A result waiting on m_tready does not stop the next vertex from being taken;
// only a further last vertex waits for the output register to empty.
//
module polyline_nearest_cut_finder #(
  parameter int MAX_POINTS = 4096
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // point_x [31:0], point_y [63:32]
  input  logic        s_tlast,   // last_point

  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // cut_segment [11:0], cut_x [43:12], cut_y [75:44], zero
  output logic [1:0]  m_tuser,   // status [1:0]

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import pnc_pkg::*;

  cmd_t        cmd;
  stat_t       st;
  logic [1:0]  out_status;
  logic [11:0] out_seg;
  logic [31:0] out_x;
  logic [31:0] out_y;

  // Registers are always writable; the host must write them only while no vertex
  // is in flight, which the block itself does not enforce.
  assign cfg_ready = 1'b1;

  pnc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .st       (st),
    .cmd      (cmd)
  );

  pnc_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_x       (s_tdata[31:0]),
    .in_y       (s_tdata[63:32]),
    .in_last    (s_tlast),
    .cmd        (cmd),
    .st         (st),
    .out_status (out_status),
    .out_seg    (out_seg),
    .out_x      (out_x),
    .out_y      (out_y)
  );

  assign m_tdata = {4'h0, out_y, out_x, out_seg};
  assign m_tuser = out_status;

endmodule

@@ src/pnc_checker.sv @@
// ---------------------------------------------------------------------------
// Nearest cut finder port checker
// Watches the top-level ports for result and handshake consistency.
// ---------------------------------------------------------------------------
`include "polyline_nearest_cut_finder_assert.svh"

module pnc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata,
  input logic [1:0]  m_tuser
);
  import pnc_pkg::*;

  // A stalled result holds.
  `PNC_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // A failed search carries no cut.
  `PNC_ASSERT_NOW(a_fail_zero, m_tvalid && (m_tuser != STATUS_CUT), m_tdata == 80'h0)

  // After taking a vertex the block is busy working on it.
  `PNC_ASSERT_NEXT(a_busy, s_tvalid && s_tready, !s_tready)

endmodule

bind polyline_nearest_cut_finder pnc_checker u_pnc_checker (.*);
